>>> hw/rtl/tga_rle_pixel_decoder_defines.svh
// Assertion macros shared by the decoder's checker.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define TRLD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("trld assertion failed");

// Next-cycle implication, off while reset is high.
`define TRLD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("trld assertion failed");

// Next-cycle implication that also holds across reset.
`define TRLD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("trld assertion failed");

`endif

>>> hw/rtl/trld_pkg.sv
`timescale 1ns / 1ps
package trld_pkg;

   localparam int unsigned MAX_RUN         = 128;
   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BYTES_PER_PIXEL = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PIXEL_COUNT     = 8'd1;

   localparam logic [2:0]  BPP_RESET         = 3'd3;
   localparam logic [31:0] PIXEL_COUNT_RESET = 32'd1;

   // configuration as seen by the front end
   typedef struct packed {
      logic [2:0]  bytes_per_pixel;
      logic [31:0] pixel_count;
      logic        count_write;
      logic [31:0] count_value;
   } cfg_type;

   // one decoded pixel result waiting for frame bookkeeping
   typedef struct packed {
      logic [31:0] pixel_value;
      logic [7:0]  repeat_count;
      logic        last_of_frame;
      logic        overflow_error;
   } entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef struct packed {
      logic [31:0] pixels_done;
   } back_status_type;

endpackage

>>> hw/rtl/trld_front.sv
`timescale 1ns / 1ps
module trld_front (
   input  logic                      clock,
   input  logic                      reset,
   input  trld_pkg::cfg_type         cfg,
   input  trld_pkg::back_status_type back_status,
   input  logic                      req_valid,
   input  logic [7:0]                req_stream_byte,
   input  logic                      queue_full,
   output logic                      accept,
   output logic                      push,
   output trld_pkg::entry_type       push_entry
);
   import trld_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_RAW,
      PH_RUN
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  chunk_left_ff, chunk_left_in;
   logic [1:0]  byte_in_pixel_ff, byte_in_pixel_in;
   logic [31:0] assembly_ff, assembly_in;
   logic [31:0] remaining_ff, remaining_in;

   logic [2:0]  bpp_eff;
   logic [2:0]  bytes_so_far;
   logic        pixel_done;
   logic [7:0]  request;
   logic        rem_fits;
   logic [7:0]  repeat_cnt;
   logic        last;
   logic        ovf;
   logic [31:0] reload;

   assign accept = req_valid && !queue_full;

   always_comb begin
      if (cfg.bytes_per_pixel == 3'd0) begin
         bpp_eff = 3'd1;
      end else if (cfg.bytes_per_pixel > 3'd4) begin
         bpp_eff = 3'd4;
      end else begin
         bpp_eff = cfg.bytes_per_pixel;
      end
   end

   assign bytes_so_far = {1'b0, byte_in_pixel_ff} + 3'd1;
   assign pixel_done   = (bytes_so_far >= bpp_eff);

   always_comb begin
      if (phase_ff == PH_RAW || chunk_left_ff == 8'd0) begin
         request = 8'd1;
      end else begin
         request = chunk_left_ff;
      end
   end

   // remaining <= request means the frame closes on this result
   assign rem_fits   = (remaining_ff <= 32'(request));
   assign repeat_cnt = rem_fits ? remaining_ff[7:0] : request;
   assign last       = rem_fits;
   assign ovf        = last && (chunk_left_ff > repeat_cnt);
   assign reload     = (cfg.pixel_count != 32'd0) ? cfg.pixel_count : 32'd1;

   always_comb begin
      phase_in         = phase_ff;
      chunk_left_in    = chunk_left_ff;
      byte_in_pixel_in = byte_in_pixel_ff;
      assembly_in      = assembly_ff;
      remaining_in     = remaining_ff;
      push             = 1'b0;

      if (cfg.count_write) begin
         remaining_in = (cfg.count_value > back_status.pixels_done) ?
                        (cfg.count_value - back_status.pixels_done) : 32'd1;
      end

      if (accept) begin
         unique case (phase_ff) inside
            PH_RAW, PH_RUN: begin
               if (byte_in_pixel_ff == 2'd0) begin
                  assembly_in = 32'(req_stream_byte);
               end else begin
                  assembly_in = assembly_ff |
                                (32'(req_stream_byte) << {byte_in_pixel_ff, 3'b000});
               end
               if (!pixel_done) begin
                  byte_in_pixel_in = byte_in_pixel_ff + 2'd1;
               end else begin
                  byte_in_pixel_in = 2'd0;
                  push             = 1'b1;
                  if (phase_ff == PH_RAW) begin
                     chunk_left_in = (chunk_left_ff != 8'd0) ? chunk_left_ff - 8'd1 : 8'd0;
                     if (chunk_left_in == 8'd0) begin
                        phase_in = PH_HEADER;
                     end
                  end else begin
                     chunk_left_in = 8'd0;
                     phase_in      = PH_HEADER;
                  end
                  if (last) begin
                     chunk_left_in = 8'd0;
                     phase_in      = PH_HEADER;
                     remaining_in  = reload;
                  end else begin
                     remaining_in  = remaining_ff - 32'(repeat_cnt);
                  end
               end
            end
            default: begin
               if (32'(req_stream_byte) < MAX_RUN) begin
                  phase_in      = PH_RAW;
                  chunk_left_in = req_stream_byte + 8'd1;
               end else begin
                  phase_in      = PH_RUN;
                  chunk_left_in = req_stream_byte - 8'(MAX_RUN - 1);
               end
               byte_in_pixel_in = 2'd0;
            end
         endcase
      end
   end

   assign push_entry.pixel_value    = assembly_in;
   assign push_entry.repeat_count   = repeat_cnt;
   assign push_entry.last_of_frame  = last;
   assign push_entry.overflow_error = ovf;

   always_ff @(posedge clock) begin
      assembly_ff <= assembly_in;
      if (reset) begin
         phase_ff         <= PH_HEADER;
         chunk_left_ff    <= 8'd0;
         byte_in_pixel_ff <= 2'd0;
         remaining_ff     <= PIXEL_COUNT_RESET;
      end else begin
         phase_ff         <= phase_in;
         chunk_left_ff    <= chunk_left_in;
         byte_in_pixel_ff <= byte_in_pixel_in;
         remaining_ff     <= remaining_in;
      end
   end

endmodule

>>> hw/rtl/trld_queue.sv
`timescale 1ns / 1ps
module trld_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  trld_pkg::entry_type        push_entry,
   input  logic                       pop,
   output trld_pkg::entry_type        head,
   output trld_pkg::queue_status_type status
);
   import trld_pkg::*;

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type          mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign head             = mem[rd_ptr_ff];
   assign status.full      = (count_ff == CNT_W'(DEPTH));
   assign status.not_empty = (count_ff != '0);

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/trld_back.sv
`timescale 1ns / 1ps
module trld_back (
   input  logic                       clock,
   input  logic                       reset,
   input  trld_pkg::queue_status_type queue_status,
   input  trld_pkg::entry_type        head,
   output logic                       pop,
   output trld_pkg::back_status_type  status,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [31:0]                rsp_pixel_value,
   output logic [7:0]                 rsp_repeat_count,
   output logic [31:0]                rsp_start_index,
   output logic                       rsp_last_of_frame,
   output logic                       rsp_overflow_error
);
   import trld_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] pixels_done_ff, pixels_done_in;
   logic [31:0] pixel_value_ff;
   logic [7:0]  repeat_count_ff;
   logic [31:0] start_index_ff;
   logic        last_ff;
   logic        ovf_ff;

   assign pop = queue_status.not_empty && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      pixels_done_in = pixels_done_ff;
      if (pop) begin
         rsp_valid_in   = 1'b1;
         pixels_done_in = head.last_of_frame ? 32'd0 :
                          pixels_done_ff + 32'(head.repeat_count);
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pixel_value_ff  <= head.pixel_value;
         repeat_count_ff <= head.repeat_count;
         start_index_ff  <= pixels_done_ff;
         last_ff         <= head.last_of_frame;
         ovf_ff          <= head.overflow_error;
      end
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         pixels_done_ff <= 32'd0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         pixels_done_ff <= pixels_done_in;
      end
   end

   assign status.pixels_done = pixels_done_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_value    = pixel_value_ff;
   assign rsp_repeat_count   = repeat_count_ff;
   assign rsp_start_index    = start_index_ff;
   assign rsp_last_of_frame  = last_ff;
   assign rsp_overflow_error = ovf_ff;

endmodule

>>> hw/rtl/tga_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// Run-length pixel decoder: takes one coded byte per cycle on req_ while
// req_stall is low and hands out one result per completed pixel on rsp_ (a
// run gives one result with its repeat count; the consumer expands it).
// Header bytes give no result. The front end decodes each byte as it is
// accepted; results go through a QUEUE_DEPTH-entry queue and a one-entry
// output register, so req_stall rises only once that queue is full while
// rsp_stall is held. A result enters the queue at the edge that accepts the
// pixel's last byte, then moves to the output register that drives rsp_valid.
// Configuration writes are always taken (csr_ready is tied high) and are
// meant to happen with the block drained.
module tga_rle_pixel_decoder #(
   parameter int unsigned QUEUE_DEPTH = 2   // 2 or more
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_stream_byte,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [31:0]                          rsp_pixel_value,
   output logic [7:0]                           rsp_repeat_count,
   output logic [31:0]                          rsp_start_index,
   output logic                                 rsp_last_of_frame,
   output logic                                 rsp_overflow_error,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [trld_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [trld_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import trld_pkg::*;

   // configuration registers
   logic [2:0]  bpp_ff;
   logic [31:0] pixel_count_ff;
   logic        csr_write;

   cfg_type          cfg;
   back_status_type  back_status;
   queue_status_type queue_status;
   entry_type        push_entry;
   entry_type        head;
   logic             accept;
   logic             push;
   logic             pop;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff         <= BPP_RESET;
         pixel_count_ff <= PIXEL_COUNT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_BYTES_PER_PIXEL: bpp_ff         <= csr_data[2:0];
            CSR_PIXEL_COUNT:     pixel_count_ff <= csr_data[31:0];
            default: ;           // unmapped index: ignored
         endcase
      end
   end

   // a pixel count write also reloads the front end's remaining-pixel count
   assign cfg.bytes_per_pixel = bpp_ff;
   assign cfg.pixel_count     = pixel_count_ff;
   assign cfg.count_write     = csr_write && (csr_index == CSR_PIXEL_COUNT);
   assign cfg.count_value     = csr_data[31:0];

   // front: header decode, byte gathering, clamp against the frame
   trld_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .back_status     (back_status),
      .req_valid       (req_valid),
      .req_stream_byte (req_stream_byte),
      .queue_full      (queue_status.full),
      .accept          (accept),
      .push            (push),
      .push_entry      (push_entry)
   );

   assign req_stall = queue_status.full;

   trld_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push && accept),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   // back: start index bookkeeping and the output register
   trld_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_status       (queue_status),
      .head               (head),
      .pop                (pop),
      .status             (back_status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_value    (rsp_pixel_value),
      .rsp_repeat_count   (rsp_repeat_count),
      .rsp_start_index    (rsp_start_index),
      .rsp_last_of_frame  (rsp_last_of_frame),
      .rsp_overflow_error (rsp_overflow_error)
   );

endmodule

>>> hw/rtl/trld_checker.sv
`timescale 1ns / 1ps
`include "tga_rle_pixel_decoder_defines.svh"
module trld_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pixel_value,
   input logic [7:0]  rsp_repeat_count,
   input logic [31:0] rsp_start_index,
   input logic        rsp_last_of_frame,
   input logic        rsp_overflow_error
);

   // stalled result holds
   `TRLD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_value) && $stable(rsp_repeat_count) && $stable(rsp_start_index))
   // overflow only on the result that closes the frame
   `TRLD_ASSERT_NOW(a_ovf_last, clock, reset, rsp_valid && rsp_overflow_error, rsp_last_of_frame)
   // repeat count stays within one chunk
   `TRLD_ASSERT_NOW(a_repeat_range, clock, reset, rsp_valid, rsp_repeat_count != 8'd0 && rsp_repeat_count <= 8'd128)
   // reset leaves no result pending
   `TRLD_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind tga_rle_pixel_decoder trld_checker u_trld_checker (.*);
